// ===== hw/rtl/epdf_pkg.sv =====
`timescale 1ns / 1ps

package epdf_pkg;

   localparam int TICK_W  = 16;
   localparam int DIST_W  = 11;
   localparam int REPEAT_W = 8;
   localparam int CSR_W   = 11;

   localparam logic [TICK_W-1:0] WRAP_TOP = 16'hffff;
   localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

   typedef enum logic [1:0] {
      CSR_NEAR_LIMIT   = 2'd0,
      CSR_JUMP_LIMIT   = 2'd1,
      CSR_REPEAT_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIST_W-1:0]   near_limit;
      logic [DIST_W-1:0]   jump_limit;
      logic [REPEAT_W-1:0] repeat_limit;
   } cfg_type;

   typedef struct packed {
      logic                was_rejected;
      logic [DIST_W-1:0]   filtered_distance;
      logic [DIST_W-1:0]   raw_distance;
   } result_type;

endpackage

// ===== hw/rtl/echo_pulse_distance_filter.sv =====
`timescale 1ns / 1ps
// Path: req_ -> queue -> product register -> result register -> rsp_.
// Throughput: one word per clock until its 4-entry queue fills; the constant-divide
// multiplier and filter stage sit behind that queue, so each side stalls on its own.
// Reset: synchronous, clears pulse tracking, queue, pipeline and filter state,
// and loads the limit registers with their defaults.
module echo_pulse_distance_filter #(
   parameter int TICKS_PER_UNIT = 58,
   parameter int QUEUE_DEPTH    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] capture_count
   input  logic        req_tuser,   // [0] for_this_channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [10:0] raw_distance, [21:11] filtered_distance,
                                    // [22] was_rejected, [23] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);
   import epdf_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              accept;
   logic              q_push, q_full, q_pop, q_valid;
   logic [TICK_W-1:0] q_push_ticks, q_pop_ticks;
   result_type        result;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = {1'b0, result};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_NEAR_LIMIT:   cfg_in.near_limit   = csr_wdata;
            CSR_JUMP_LIMIT:   cfg_in.jump_limit   = csr_wdata;
            CSR_REPEAT_LIMIT: cfg_in.repeat_limit = csr_wdata[REPEAT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit   <= 11'd10;
         cfg_ff.jump_limit   <= 11'd30;
         cfg_ff.repeat_limit <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   epdf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .capture_count    (req_tdata),
      .for_this_channel (req_tuser),
      .push             (q_push),
      .push_ticks       (q_push_ticks)
   );

   epdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ticks (q_push_ticks),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_ticks  (q_pop_ticks)
   );

   epdf_back #(
      .TICKS_PER_UNIT (TICKS_PER_UNIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (q_valid),
      .pop_ticks  (q_pop_ticks),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (accept && req_tuser))
      else $error("push without accepted word");

   a_reject_differs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.was_rejected) |->
         (result.raw_distance != result.filtered_distance))
      else $error("rejected reading equals reported distance");

   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== hw/rtl/epdf_front.sv =====
`timescale 1ns / 1ps

module epdf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [epdf_pkg::TICK_W-1:0]  capture_count,
   input  logic                         for_this_channel,
   output logic                         push,
   output logic [epdf_pkg::TICK_W-1:0]  push_ticks
);
   import epdf_pkg::*;

   logic              awaiting_end_ff, awaiting_end_in;
   logic [TICK_W-1:0] start_count_ff, start_count_in;

   always_comb begin
      awaiting_end_in = awaiting_end_ff;
      start_count_in  = start_count_ff;
      push            = 1'b0;
      if (accept && for_this_channel) begin
         if (!awaiting_end_ff) begin
            start_count_in  = capture_count;
            awaiting_end_in = 1'b1;
         end else begin
            awaiting_end_in = 1'b0;
            push            = 1'b1;
         end
      end
      if (capture_count > start_count_ff) begin
         push_ticks = capture_count - start_count_ff;
      end else if (capture_count < start_count_ff) begin
         push_ticks = (WRAP_TOP - start_count_ff) + capture_count;
      end else begin
         push_ticks = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_end_ff <= 1'b0;
         start_count_ff  <= '0;
      end else begin
         awaiting_end_ff <= awaiting_end_in;
         start_count_ff  <= start_count_in;
      end
   end

endmodule

// ===== hw/rtl/epdf_queue.sv =====
`timescale 1ns / 1ps

module epdf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [epdf_pkg::TICK_W-1:0]  push_ticks,
   output logic                         full,
   input  logic                         pop,
   output logic                         pop_valid,
   output logic [epdf_pkg::TICK_W-1:0]  pop_ticks
);
   import epdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [TICK_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_ticks = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/epdf_back.sv =====
`timescale 1ns / 1ps

module epdf_back #(
   parameter int TICKS_PER_UNIT = 58
) (
   input  logic                         clock,
   input  logic                         reset,
   input  epdf_pkg::cfg_type            cfg,
   input  logic                         pop_valid,
   input  logic [epdf_pkg::TICK_W-1:0]  pop_ticks,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output epdf_pkg::result_type         out_result
);
   import epdf_pkg::*;

   localparam int DIV_EFF   = (TICKS_PER_UNIT < 1) ? 1 : TICKS_PER_UNIT;
   localparam int DIV_SHIFT = TICK_W + $clog2(DIV_EFF);
   localparam int MULT_W    = TICK_W + 1;
   localparam int PROD_W    = TICK_W + MULT_W;
   localparam logic [63:0] MULT_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(DIV_EFF) - 64'd1) / 64'(DIV_EFF);
   localparam logic [MULT_W-1:0] MULT = MULT_FULL[MULT_W-1:0];

   logic              m_valid_ff, m_valid_in;
   logic [PROD_W-1:0] prod_ff;
   logic              o_valid_ff, o_valid_in;
   result_type        result_ff;
   logic              out_adv, m_load;

   logic [DIST_W-1:0]   ref_ff, ref_in;
   logic [DIST_W-1:0]   shown_ff, shown_in;
   logic [REPEAT_W-1:0] same_ff, same_in;

   logic [TICK_W-1:0]   quot;
   logic [DIST_W-1:0]   raw, diff;
   logic [REPEAT_W-1:0] same_inc;
   logic                rejected;

   assign out_adv    = !o_valid_ff || out_ready;
   assign m_load     = !m_valid_ff || out_adv;
   assign pop        = m_load;
   assign m_valid_in = m_load ? pop_valid : m_valid_ff;
   assign o_valid_in = out_adv ? m_valid_ff : o_valid_ff;
   assign out_valid  = o_valid_ff;
   assign out_result = result_ff;

   always_comb begin
      quot     = TICK_W'(prod_ff >> DIV_SHIFT);
      raw      = (quot > TICK_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
      diff     = (raw > ref_ff) ? raw - ref_ff : ref_ff - raw;
      same_inc = same_ff + 1'b1;
      ref_in   = ref_ff;
      shown_in = shown_ff;
      same_in  = same_ff;
      rejected = 1'b0;
      if (raw < cfg.near_limit) begin
         shown_in = raw;
         ref_in   = raw;
         same_in  = '0;
      end else if (diff == '0) begin
         if (same_inc > cfg.repeat_limit) begin
            same_in  = '0;
            shown_in = ref_ff;
         end else begin
            same_in = same_inc;
         end
      end else if (diff > cfg.jump_limit) begin
         shown_in = ref_ff;
         same_in  = '0;
         rejected = 1'b1;
      end else begin
         shown_in = raw;
         ref_in   = raw;
         same_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (m_load && pop_valid) begin
         prod_ff <= PROD_W'(pop_ticks) * PROD_W'(MULT);
      end
      if (out_adv && m_valid_ff) begin
         result_ff.raw_distance      <= raw;
         result_ff.filtered_distance <= shown_in;
         result_ff.was_rejected      <= rejected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         ref_ff     <= '0;
         shown_ff   <= '0;
         same_ff    <= '0;
      end else begin
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
         if (out_adv && m_valid_ff) begin
            ref_ff   <= ref_in;
            shown_ff <= shown_in;
            same_ff  <= same_in;
         end
      end
   end

endmodule
